>>> rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared widths, constants and types of the potentiometer angle block.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int SAMPLE_W            = 10;
  localparam int RAW_W               = 12;
  localparam int OHMS_W              = 16;
  localparam int ANGLE_W             = 12;
  localparam int SAMPLES_PER_READING = 16;
  localparam int COUNT_W             = $clog2(SAMPLES_PER_READING);
  localparam int SUM_W               = SAMPLE_W + COUNT_W;

  localparam int FIXED_RESISTOR_OHMS = 10000;
  localparam int DEFAULT_CCW_OHMS    = 0;
  localparam int DEFAULT_CW_OHMS     = 10000;
  localparam int CAL_MAGIC_WORD      = 42405;

  localparam int RAW_CLAMP = 4000;
  localparam int RAW_FULL  = 4092;
  localparam int FULL_TURN = 3600;
  localparam int MIN_SPAN  = 100;
  localparam int OHMS_MAX  = 65535;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_CAP_CCW = 2'd1,
    OP_CAP_CW  = 2'd2,
    OP_LOAD    = 2'd3
  } op_t;

  // One queued command; OP_SAMPLE stands for a finished sample group.
  typedef struct packed {
    op_t                kind;
    logic [RAW_W-1:0]   raw;
    logic [OHMS_W-1:0]  ccw;
    logic [OHMS_W-1:0]  cw;
  } queue_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_OHMS_GO,
    BK_OHMS_WAIT,
    BK_ANGLE_MUL,
    BK_ANGLE_GO,
    BK_ANGLE_WAIT,
    BK_SEND
  } back_state_t;

endpackage

>>> rtl/ppd_div.sv
// ----------------------------------------------------------------------------
// ppd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppd_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0]  work;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] steps;
  logic              busy;

  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, work[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign quot  = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W - 1);
      end else if (busy) begin
        if (steps == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          steps <= steps - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      // shift the quotient bit in where the numerator bit leaves
      rem  <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      work <= {work[NUM_W-2:0], fits};
    end
  end

endmodule

>>> rtl/ppd_queue.sv
// ----------------------------------------------------------------------------
// ppd_queue
// Short command queue between the sample front end and the compute back end.
// ----------------------------------------------------------------------------
module ppd_queue
  import ppd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output queue_entry_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> rtl/ppd_front.sv
// ----------------------------------------------------------------------------
// ppd_front
// Accepts items, sums sample groups and checks calibration records.
// ----------------------------------------------------------------------------
module ppd_front
  import ppd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [SAMPLE_W-1:0] adc_sample,
  input  logic [OHMS_W-1:0]   load_magic,
  input  logic [OHMS_W-1:0]   load_ccw_ohms,
  input  logic [OHMS_W-1:0]   load_cw_ohms,
  input  logic                q_full,
  output logic                q_push,
  output queue_entry_t        q_entry
);

  logic [SUM_W-1:0]   sample_sum;
  logic [COUNT_W-1:0] sample_count;

  op_t                op;
  logic               accept;
  logic               last_sample;
  logic [SUM_W-1:0]   sum_next;
  logic signed [OHMS_W:0] rec_span;
  logic               rec_ok;

  assign op          = op_t'(operation);
  assign in_ready    = !q_full;
  assign accept      = in_valid && in_ready;
  assign last_sample = sample_count == COUNT_W'(SAMPLES_PER_READING - 1);
  assign sum_next    = sample_sum + SUM_W'(adc_sample);

  // span of the record with both ends read as signed 16-bit values
  assign rec_span = $signed({load_cw_ohms[OHMS_W-1], load_cw_ohms})
                  - $signed({load_ccw_ohms[OHMS_W-1], load_ccw_ohms});
  assign rec_ok   = (load_magic == OHMS_W'(CAL_MAGIC_WORD))
                 && ((rec_span > $signed((OHMS_W+1)'(MIN_SPAN)))
                  || (rec_span < -$signed((OHMS_W+1)'(MIN_SPAN))));

  assign q_push = accept && ((op != OP_SAMPLE) || last_sample);

  always_comb begin
    q_entry.kind = op;
    q_entry.raw  = sum_next[SUM_W-1:SUM_W-RAW_W];
    q_entry.ccw  = rec_ok ? load_ccw_ohms : OHMS_W'(DEFAULT_CCW_OHMS);
    q_entry.cw   = rec_ok ? load_cw_ohms  : OHMS_W'(DEFAULT_CW_OHMS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept && (op == OP_SAMPLE)) begin
      if (last_sample) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_next;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

endmodule

>>> rtl/ppd_back.sv
// ----------------------------------------------------------------------------
// ppd_back
// Runs queued commands: resistance and angle divisions, calibration updates.
// ----------------------------------------------------------------------------
module ppd_back
  import ppd_pkg::*;
#(
  parameter int FIXED_OHMS = FIXED_RESISTOR_OHMS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  queue_entry_t       q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [RAW_W-1:0]   raw_reading,
  output logic [OHMS_W-1:0]  track_ohms,
  output logic [ANGLE_W-1:0] angle_tenths,
  output logic               open_track,
  output logic               span_zero
);

  localparam int FIXED_W     = $clog2(FIXED_OHMS + 1);
  localparam int OHMS_NUM_W  = FIXED_W + RAW_W;
  localparam int ANGLE_NUM_W = OHMS_W + ANGLE_W;
  localparam int DIV_NUM_W   = (OHMS_NUM_W > ANGLE_NUM_W) ? OHMS_NUM_W : ANGLE_NUM_W;

  back_state_t state, state_next;

  logic [OHMS_W-1:0]    ccw_ohms;
  logic [OHMS_W-1:0]    cw_ohms;
  logic [OHMS_W-1:0]    last_ohms;
  logic [DIV_NUM_W-1:0] div_num;
  logic [OHMS_W-1:0]    div_den;
  logic                 angle_neg;

  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  logic [RAW_W-1:0]     used;
  logic [OHMS_W-1:0]    ohms_sat;
  logic [OHMS_W:0]      span;
  logic [OHMS_W:0]      diff;
  logic [OHMS_W:0]      span_mag;
  logic [OHMS_W:0]      diff_mag;
  logic [ANGLE_NUM_W-1:0] angle_prod;

  assign used     = (q_head.raw > RAW_W'(RAW_CLAMP)) ? RAW_W'(RAW_CLAMP) : q_head.raw;
  assign ohms_sat = (div_quot > DIV_NUM_W'(OHMS_MAX)) ? OHMS_W'(OHMS_MAX)
                                                      : div_quot[OHMS_W-1:0];
  assign span     = {1'b0, cw_ohms} - {1'b0, ccw_ohms};
  assign diff     = {1'b0, track_ohms} - {1'b0, ccw_ohms};
  assign span_mag = span[OHMS_W] ? -span : span;
  assign diff_mag = diff[OHMS_W] ? -diff : diff;
  assign angle_prod = ANGLE_NUM_W'(diff_mag[OHMS_W-1:0]) * ANGLE_NUM_W'(FULL_TURN);

  ppd_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (OHMS_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && (q_head.kind == OP_SAMPLE)) begin
          state_next = BK_OHMS_GO;
        end
      end
      BK_OHMS_GO:   state_next = BK_OHMS_WAIT;
      BK_OHMS_WAIT: if (div_done) state_next = BK_ANGLE_MUL;
      BK_ANGLE_MUL: state_next = BK_ANGLE_GO;
      BK_ANGLE_GO:  state_next = span_zero ? BK_SEND : BK_ANGLE_WAIT;
      BK_ANGLE_WAIT: if (div_done) state_next = BK_SEND;
      BK_SEND:      if (out_ready) state_next = BK_IDLE;
      default:      state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == BK_IDLE) && q_valid;
    div_start = (state == BK_OHMS_GO) || ((state == BK_ANGLE_GO) && !span_zero);
    out_valid = state == BK_SEND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      ccw_ohms  <= OHMS_W'(DEFAULT_CCW_OHMS);
      cw_ohms   <= OHMS_W'(DEFAULT_CW_OHMS);
      last_ohms <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        unique case (q_head.kind)
          OP_SAMPLE:  ;
          OP_CAP_CCW: ccw_ohms <= last_ohms;
          OP_CAP_CW:  cw_ohms  <= last_ohms;
          OP_LOAD: begin
            ccw_ohms <= q_head.ccw;
            cw_ohms  <= q_head.cw;
          end
        endcase
      end
      if ((state == BK_OHMS_WAIT) && div_done) begin
        last_ohms <= ohms_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        raw_reading <= q_head.raw;
        open_track  <= q_head.raw > RAW_W'(RAW_CLAMP);
        div_num     <= DIV_NUM_W'(OHMS_NUM_W'(FIXED_OHMS) * OHMS_NUM_W'(used));
        div_den     <= OHMS_W'(RAW_W'(RAW_FULL) - used);
      end
      BK_OHMS_WAIT: begin
        if (div_done) begin
          track_ohms <= ohms_sat;
        end
      end
      BK_ANGLE_MUL: begin
        div_num   <= DIV_NUM_W'(angle_prod);
        div_den   <= span_mag[OHMS_W-1:0];
        angle_neg <= diff[OHMS_W] ^ span[OHMS_W];
        span_zero <= span == '0;
      end
      BK_ANGLE_GO: begin
        if (span_zero) begin
          angle_tenths <= '0;
        end
      end
      BK_ANGLE_WAIT: begin
        // clamp: negative angle to zero, past a full turn to a full turn
        if (div_done) begin
          if (angle_neg) begin
            angle_tenths <= '0;
          end else if (div_quot > DIV_NUM_W'(FULL_TURN)) begin
            angle_tenths <= ANGLE_W'(FULL_TURN);
          end else begin
            angle_tenths <= div_quot[ANGLE_W-1:0];
          end
        end
      end
      BK_OHMS_GO, BK_SEND: ;
      default: ;
    endcase
  end

endmodule

>>> rtl/pot_position_to_degrees.sv
// ----------------------------------------------------------------------------
// pot_position_to_degrees
// Potentiometer angle sensor: sample groups to resistance and tenths of degree.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries an operation and its fields: a
// converter sample, a capture of the last resistance as the CCW or CW end, or
// a calibration record, checked on entry and replaced by defaults if bad.
// Every 16th sample closes a group and yields one item on the output channel
// (out_valid/out_ready); other items yield nothing.
// The shared one-bit-per-cycle divider, 28 bits wide at the default fixed
// resistor, runs once for the resistance and, unless the span is zero, once
// more for the angle. Captures and loads act in the back end as they leave
// the queue, with no division.
// A two-entry queue parts front and back: samples keep coming in while the
// back end divides or a result waits; in_ready drops only when it is full.
// A stalled receiver holds the result; later groups pile into the queue.
// Reset clears the group sum and count, the queue and the last resistance,
// and restores the default calibration ends.
// ----------------------------------------------------------------------------
module pot_position_to_degrees
  import ppd_pkg::*;
#(
  parameter int FIXED_OHMS = FIXED_RESISTOR_OHMS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [SAMPLE_W-1:0] adc_sample,
  input  logic [OHMS_W-1:0]  load_magic,
  input  logic [OHMS_W-1:0]  load_ccw_ohms,
  input  logic [OHMS_W-1:0]  load_cw_ohms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [RAW_W-1:0]   raw_reading,
  output logic [OHMS_W-1:0]  track_ohms,
  output logic [ANGLE_W-1:0] angle_tenths,
  output logic               open_track,
  output logic               span_zero
);

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  queue_entry_t q_entry;
  queue_entry_t q_head;

  ppd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .adc_sample    (adc_sample),
    .load_magic    (load_magic),
    .load_ccw_ohms (load_ccw_ohms),
    .load_cw_ohms  (load_cw_ohms),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  ppd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  ppd_back #(
    .FIXED_OHMS (FIXED_OHMS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .raw_reading  (raw_reading),
    .track_ohms   (track_ohms),
    .angle_tenths (angle_tenths),
    .open_track   (open_track),
    .span_zero    (span_zero)
  );

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the potentiometer angle block against an in-bench position model.
// Every accepted item updates the model; every 16th sample queues one expected
// reading, compared field by field with what the block returns. Both sides
// idle at random, and the receiver once holds off long enough to fill the
// block and stall its input.
// ----------------------------------------------------------------------------
module testbench
  import ppd_pkg::*;
;

  typedef struct packed {
    logic [RAW_W-1:0]   raw;
    logic [OHMS_W-1:0]  ohms;
    logic [ANGLE_W-1:0] angle;
    logic               open_trk;
    logic               zero_span;
  } reading_t;

  localparam int ITEM_TARGET = 1950;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          operation = OP_SAMPLE;
  logic [SAMPLE_W-1:0] adc_sample = '0;
  logic [OHMS_W-1:0]   load_magic = '0;
  logic [OHMS_W-1:0]   load_ccw_ohms = '0;
  logic [OHMS_W-1:0]   load_cw_ohms = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [RAW_W-1:0]    raw_reading;
  logic [OHMS_W-1:0]   track_ohms;
  logic [ANGLE_W-1:0]  angle_tenths;
  logic                open_track;
  logic                span_zero;

  // position model state
  logic [SUM_W-1:0]    grp_sum = '0;
  int                  grp_count = 0;
  logic [OHMS_W-1:0]   cal_ccw = 16'(DEFAULT_CCW_OHMS);
  logic [OHMS_W-1:0]   cal_cw = 16'(DEFAULT_CW_OHMS);
  logic [OHMS_W-1:0]   prev_ohms = '0;
  reading_t            pending_readings[$];

  bit calm = 1'b0;
  int hold_request = 0;
  int items_sent = 0;
  int readings_checked = 0;
  int open_seen = 0;
  int saturated_seen = 0;
  int zero_span_seen = 0;
  int records_taken = 0;
  int mismatches = 0;

  pot_position_to_degrees dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .adc_sample    (adc_sample),
    .load_magic    (load_magic),
    .load_ccw_ohms (load_ccw_ohms),
    .load_cw_ohms  (load_cw_ohms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .raw_reading   (raw_reading),
    .track_ohms    (track_ohms),
    .angle_tenths  (angle_tenths),
    .open_track    (open_track),
    .span_zero     (span_zero)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 90);
  endfunction

  function automatic bit record_valid(logic [OHMS_W-1:0] magic, logic [OHMS_W-1:0] ccw,
                                      logic [OHMS_W-1:0] cw);
    shortint s_ccw;
    shortint s_cw;
    int      span;
    s_ccw = ccw;
    s_cw  = cw;
    span  = int'(s_cw) - int'(s_ccw);
    return magic == 16'(CAL_MAGIC_WORD) && (span > MIN_SPAN || span < -MIN_SPAN);
  endfunction

  function automatic reading_t group_reading(logic [SUM_W-1:0] sum);
    reading_t r;
    int       used;
    longint   ohms;
    longint   span;
    longint   deg;
    r.raw      = sum[SUM_W-1:2];
    r.open_trk = 1'b0;
    r.zero_span = 1'b0;
    used = int'(r.raw);
    if (used > RAW_CLAMP) begin
      used = RAW_CLAMP;
      r.open_trk = 1'b1;
    end
    ohms = (longint'(FIXED_RESISTOR_OHMS) * used) / (RAW_FULL - used);
    if (ohms > OHMS_MAX) ohms = OHMS_MAX;
    r.ohms = ohms[OHMS_W-1:0];
    span = longint'(cal_cw) - longint'(cal_ccw);
    if (span == 0) begin
      deg = 0;
      r.zero_span = 1'b1;
    end else begin
      // signed division truncates toward zero
      deg = ((ohms - longint'(cal_ccw)) * FULL_TURN) / span;
      if (deg < 0) deg = 0;
      if (deg > FULL_TURN) deg = FULL_TURN;
    end
    r.angle = deg[ANGLE_W-1:0];
    return r;
  endfunction

  function automatic void predict_reading(op_t op, logic [SAMPLE_W-1:0] sample,
                                          logic [OHMS_W-1:0] magic,
                                          logic [OHMS_W-1:0] ccw, logic [OHMS_W-1:0] cw);
    reading_t r;
    case (op)
      OP_SAMPLE: begin
        grp_sum = grp_sum + SUM_W'(sample);
        grp_count++;
        if (grp_count >= SAMPLES_PER_READING) begin
          r = group_reading(grp_sum);
          prev_ohms = r.ohms;
          pending_readings.push_back(r);
          if (r.open_trk) open_seen++;
          if (r.ohms == 16'(OHMS_MAX)) saturated_seen++;
          if (r.zero_span) zero_span_seen++;
          grp_sum = '0;
          grp_count = 0;
        end
      end
      OP_CAP_CCW: cal_ccw = prev_ohms;
      OP_CAP_CW:  cal_cw = prev_ohms;
      default: begin
        if (record_valid(magic, ccw, cw)) begin
          cal_ccw = ccw;
          cal_cw  = cw;
          records_taken++;
        end else begin
          cal_ccw = 16'(DEFAULT_CCW_OHMS);
          cal_cw  = 16'(DEFAULT_CW_OHMS);
        end
      end
    endcase
  endfunction

  // Valid stays high across back-to-back items; drop it only for a gap.
  task automatic send_item(op_t op, logic [SAMPLE_W-1:0] sample, logic [OHMS_W-1:0] magic,
                           logic [OHMS_W-1:0] ccw, logic [OHMS_W-1:0] cw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    adc_sample    <= sample;
    load_magic    <= magic;
    load_ccw_ohms <= ccw;
    load_cw_ohms  <= cw;
    do @(posedge clk); while (!in_ready);
    predict_reading(op, sample, magic, ccw, cw);
    items_sent++;
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] sample);
    send_item(OP_SAMPLE, sample, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_capture(op_t op);
    send_item(op, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_record(logic [OHMS_W-1:0] magic, logic [OHMS_W-1:0] ccw,
                             logic [OHMS_W-1:0] cw);
    send_item(OP_LOAD, 10'($urandom), magic, ccw, cw);
  endtask

  // One group of samples around a level; a capture or load may land mid-group.
  task automatic send_group();
    int kind;
    int level;
    int v;
    int cut;
    kind  = $urandom_range(0, 99);
    level = (kind < 15) ? $urandom_range(750, 1023) : $urandom_range(0, 1023);
    cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 0;
    for (int i = 0; i < SAMPLES_PER_READING; i++) begin
      if (i == cut && cut != 0) begin
        if ($urandom_range(0, 1)) send_capture(op_t'($urandom_range(1, 2)));
        else send_record(16'($urandom), 16'($urandom), 16'($urandom));
      end
      if (kind >= 90) v = 1023;
      else if (kind >= 80) v = 0;
      else begin
        v = level + $urandom_range(0, 16) - 8;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end
      send_sample(v[SAMPLE_W-1:0]);
    end
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  task automatic check_reading();
    reading_t want;
    if (pending_readings.size() == 0) begin
      $error("reading with none expected: raw %0d ohms %0d angle %0d",
             raw_reading, track_ohms, angle_tenths);
      mismatches++;
      return;
    end
    want = pending_readings.pop_front();
    check_field("raw_reading", int'(want.raw), int'(raw_reading));
    check_field("track_ohms", int'(want.ohms), int'(track_ohms));
    check_field("angle_tenths", int'(want.angle), int'(angle_tenths));
    check_field("open_track", int'(want.open_trk), int'(open_track));
    check_field("span_zero", int'(want.zero_span), int'(span_zero));
    readings_checked++;
  endtask

  initial begin : result_monitor
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) check_reading();
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Captures before any reading store 0 on both ends: zero span.
  // A full-scale group then gives an open track and a saturated resistance.
  task automatic test_capture_before_reading();
    send_capture(OP_CAP_CCW);
    send_capture(OP_CAP_CW);
    for (int i = 0; i < SAMPLES_PER_READING; i++) send_sample('1);
  endtask

  task automatic test_record_check();
    send_record(16'(CAL_MAGIC_WORD) ^ 16'h0001, 16'd100, 16'd9000);
    send_record(16'(CAL_MAGIC_WORD), 16'd200, 16'd300);
    send_record(16'(CAL_MAGIC_WORD), 16'h8000, 16'h7fff);
    send_record(16'(CAL_MAGIC_WORD), 16'd0, 16'd101);
  endtask

  // Hold the receiver off while samples keep coming, so the queue fills.
  task automatic test_backpressure();
    calm = 1'b1;
    hold_request = 400;
    for (int g = 0; g < 4; g++) send_group();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int r;
    int d;
    logic [OHMS_W-1:0] ccw;
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 72) send_group();
      else if (r < 82) send_capture(op_t'($urandom_range(1, 2)));
      else if (r < 88) send_record(16'(CAL_MAGIC_WORD), 16'($urandom_range(0, 2000)),
                                   16'($urandom_range(8000, 65535)));
      else if (r < 94) begin
        // spans right at the acceptance edge, with 16-bit wrap
        case ($urandom_range(0, 5))
          0: d = MIN_SPAN;
          1: d = -MIN_SPAN;
          2: d = MIN_SPAN + 1;
          3: d = -MIN_SPAN - 1;
          4: d = 0;
          default: d = $urandom_range(0, 65535);
        endcase
        ccw = 16'($urandom);
        send_record(16'(CAL_MAGIC_WORD), ccw, ccw + 16'(d));
      end else send_item(op_t'($urandom_range(0, 3)), 10'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_capture_before_reading();
    test_record_check();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d items, checked %0d readings; %0d records accepted.",
             items_sent, readings_checked, records_taken);
    $display("Readings with open track %0d, saturated ohms %0d, zero span %0d.",
             open_seen, saturated_seen, zero_span_seen);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
